// File: rtl/per_process_message_mailbox_defines.svh
// ----------------------------------------------------------------------------
// per_process_message_mailbox_defines
// assertion macros shared by the mailbox rtl
// ----------------------------------------------------------------------------
`ifndef PER_PROCESS_MESSAGE_MAILBOX_DEFINES_SVH
`define PER_PROCESS_MESSAGE_MAILBOX_DEFINES_SVH

// checked on every clock edge outside reset
`define PPMM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define PPMM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/ppmm_pkg.sv
// ----------------------------------------------------------------------------
// ppmm_pkg
// codes and field widths of the per-process message mailbox
// ----------------------------------------------------------------------------
`default_nettype none

package ppmm_pkg;

   // item field widths
   localparam int MODE_W   = 1;
   localparam int BOX_IN_W = 6;
   localparam int MSG_W    = 64;
   localparam int STATUS_W = 2;

   // item modes
   localparam logic [MODE_W-1:0] MODE_SEND = 1'b0;
   localparam logic [MODE_W-1:0] MODE_RECV = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// File: rtl/per_process_message_mailbox.sv
// ----------------------------------------------------------------------------
// per_process_message_mailbox
// bank of circular message queues, one per mailbox, held in block memory
// ----------------------------------------------------------------------------
// A new item is taken in every cycle that busy is low; busy is high only in
// the first cycle after reset, since no memory needs clearing (mailbox
// pointers start from valid bits). Each item gives one result through the
// s1 and s2 registers; rsp_valid is high for a single cycle and the result
// cannot be held off. The pointer memory is read in the cycle of acceptance
// and written back in the next cycle; the write of the previous item is
// forwarded, so items for the same mailbox may follow back to back. The
// message memory is read or written once per item, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_process_message_mailbox_defines.svh"

module per_process_message_mailbox
   import ppmm_pkg::*;
#(
   parameter int MAILBOX_COUNT = 64,
   parameter int QUEUE_DEPTH   = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [BOX_IN_W-1:0] req_mailbox,
   input  wire logic [MSG_W-1:0]    req_message,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [MSG_W-1:0]         rsp_received_message
);

   localparam int BOX_W  = (MAILBOX_COUNT > 1) ? $clog2(MAILBOX_COUNT) : 1;
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int WORDS  = MAILBOX_COUNT * QUEUE_DEPTH;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CMP_W  = 9;

   localparam logic [CMP_W-1:0]  BOX_LIMIT = CMP_W'(MAILBOX_COUNT);
   localparam logic [PTR_W-1:0]  LAST_POS  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [ADDR_W-1:0] ROW_SIZE  = ADDR_W'(QUEUE_DEPTH);

   typedef struct packed {
      logic [PTR_W-1:0] head;
      logic [PTR_W-1:0] tail;
      logic [CNT_W-1:0] count;
   } ptr_set_type;

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      return (p == LAST_POS) ? '0 : p + 1'b1;
   endfunction

   // memories
   ptr_set_type      ptr_mem [MAILBOX_COUNT];
   logic [MSG_W-1:0] msg_mem [WORDS];

   // registers
   logic                     busy_ff;
   logic                     s1_valid_ff;
   logic [MODE_W-1:0]        s1_mode_ff;
   logic [BOX_W-1:0]         s1_box_ff;
   logic                     s1_inrange_ff;
   logic [MSG_W-1:0]         s1_msg_ff;
   ptr_set_type              ptr_rd_ff;
   logic                     lw_valid_ff;
   logic [BOX_W-1:0]         lw_box_ff;
   ptr_set_type              lw_ptrs_ff;
   logic [MAILBOX_COUNT-1:0] valid_ff;
   logic                     s2_valid_ff;
   logic [STATUS_W-1:0]      s2_status_ff;
   logic                     s2_take_ff;
   logic [MSG_W-1:0]         msg_rd_ff;

   // combinational
   logic               accept;
   logic [CMP_W-1:0]   box_wide;
   logic [BOX_W-1:0]   box_in;
   ptr_set_type        eff_ptrs;
   ptr_set_type        new_ptrs;
   logic               is_full;
   logic               is_empty;
   logic               send_ok;
   logic               recv_ok;
   logic               ptr_wr;
   logic [STATUS_W-1:0] s1_status;
   logic [PTR_W-1:0]   pos;
   logic [ADDR_W-1:0]  msg_addr;

   assign accept   = start && !busy_ff;
   assign box_wide = CMP_W'(req_mailbox);
   assign box_in   = box_wide[BOX_W-1:0];
   assign busy     = busy_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
         valid_ff    <= '0;
      end else begin
         busy_ff     <= 1'b0;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         lw_valid_ff <= ptr_wr;
         if (ptr_wr) begin
            valid_ff[s1_box_ff] <= 1'b1;
         end
      end
   end

   // item payload through the stages
   always_ff @(posedge clock) begin
      s1_mode_ff    <= req_mode;
      s1_box_ff     <= box_in;
      s1_inrange_ff <= box_wide < BOX_LIMIT;
      s1_msg_ff     <= req_message;
      lw_box_ff     <= s1_box_ff;
      lw_ptrs_ff    <= new_ptrs;
      s2_status_ff  <= s1_status;
      s2_take_ff    <= recv_ok;
   end

   // pointer memory: read on acceptance, write back in the next cycle
   always_ff @(posedge clock) begin
      ptr_rd_ff <= ptr_mem[box_in];
      if (ptr_wr) begin
         ptr_mem[s1_box_ff] <= new_ptrs;
      end
   end

   // pointer forwarding and update
   always_comb begin
      if (lw_valid_ff && (lw_box_ff == s1_box_ff)) begin
         eff_ptrs = lw_ptrs_ff;
      end else if (valid_ff[s1_box_ff]) begin
         eff_ptrs = ptr_rd_ff;
      end else begin
         eff_ptrs = '0;
      end

      is_full  = eff_ptrs.count == FULL_CNT;
      is_empty = eff_ptrs.count == '0;
      send_ok  = s1_valid_ff && s1_inrange_ff && (s1_mode_ff == MODE_SEND) && !is_full;
      recv_ok  = s1_valid_ff && s1_inrange_ff && (s1_mode_ff == MODE_RECV) && !is_empty;
      ptr_wr   = send_ok || recv_ok;

      new_ptrs = eff_ptrs;
      if (send_ok) begin
         new_ptrs.tail  = next_pos(eff_ptrs.tail);
         new_ptrs.count = eff_ptrs.count + 1'b1;
      end else if (recv_ok) begin
         new_ptrs.head  = next_pos(eff_ptrs.head);
         new_ptrs.count = eff_ptrs.count - 1'b1;
      end

      pos      = (s1_mode_ff == MODE_SEND) ? eff_ptrs.tail : eff_ptrs.head;
      msg_addr = ADDR_W'(s1_box_ff) * ROW_SIZE + ADDR_W'(pos);
   end

   // status of the item in stage one
   always_comb begin
      case (s1_mode_ff)
         MODE_SEND: s1_status = (!s1_inrange_ff || is_full) ? ST_FULL : ST_OK;
         MODE_RECV: s1_status = (!s1_inrange_ff || is_empty) ? ST_EMPTY : ST_OK;
         default:   s1_status = ST_OK;
      endcase
   end

   // message memory
   always_ff @(posedge clock) begin
      msg_rd_ff <= msg_mem[msg_addr];
      if (send_ok) begin
         msg_mem[msg_addr] <= s1_msg_ff;
      end
   end

   // result
   assign rsp_valid            = s2_valid_ff;
   assign rsp_status           = s2_status_ff;
   assign rsp_received_message = s2_take_ff ? msg_rd_ff : '0;

   // checks
   `PPMM_ASSERT(a_rsp_after_two, accept |-> ##2 rsp_valid, "item gave no result two cycles on")
   `PPMM_ASSERT(a_count_bound, s1_valid_ff |-> eff_ptrs.count <= FULL_CNT, "fill count beyond depth")
   `PPMM_ASSERT(a_data_only_ok, rsp_valid && (rsp_status != ST_OK) |-> rsp_received_message == '0, "data on failed item")
   `PPMM_ASSERT(a_write_moves_count, ptr_wr |=> lw_ptrs_ff.count != $past(eff_ptrs.count), "pointer write left count unchanged")
   `PPMM_ASSERT_ALWAYS(a_reset_clears, reset |=> (valid_ff == '0) && !rsp_valid && busy, "reset left state behind")

endmodule

`default_nettype wire

// File: bench/mailbox_checker.sv
// ----------------------------------------------------------------------------
// mailbox_checker
// predicts and checks every result of the per-process message mailbox
// ----------------------------------------------------------------------------
// Watches the item and result channels. Each accepted item runs through a
// private copy of the mailbox queues, and the expected status and message are
// queued. Each result strobe is compared field by field with the oldest
// expectation. On drain_check, any expectation still waiting is flagged.
// ----------------------------------------------------------------------------
module mailbox_checker
   import ppmm_pkg::*;
#(
   parameter int MAILBOX_COUNT = 64,
   parameter int QUEUE_DEPTH   = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [BOX_IN_W-1:0] req_mailbox,
   input  wire logic [MSG_W-1:0]    req_message,
   input  wire logic                rsp_valid,
   input  wire logic [STATUS_W-1:0] rsp_status,
   input  wire logic [MSG_W-1:0]    rsp_received_message,
   input  wire logic                drain_check,
   output int                       results_seen,
   output int                       fail_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [MSG_W-1:0]    message;
   } mail_result_type;

   // private copy of the mailbox bank
   logic [MSG_W-1:0] box_words [MAILBOX_COUNT][QUEUE_DEPTH];
   int               head_pos   [MAILBOX_COUNT];
   int               tail_pos   [MAILBOX_COUNT];
   int               fill_level [MAILBOX_COUNT];

   mail_result_type awaited_results [$];
   int              mismatches = 0;

   assign fail_count = mismatches;

   // apply one item to the queue copy and give the result it should produce
   function automatic mail_result_type predict_mailbox_item(
      input logic [MODE_W-1:0]   mode,
      input logic [BOX_IN_W-1:0] box,
      input logic [MSG_W-1:0]    msg
   );
      mail_result_type r;
      int              b;
      b         = box;
      r.status  = ST_OK;
      r.message = '0;
      if (b >= MAILBOX_COUNT) begin
         r.status = (mode == MODE_RECV) ? ST_EMPTY : ST_FULL;
      end else if (mode == MODE_SEND) begin
         if (fill_level[b] >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            box_words[b][tail_pos[b]] = msg;
            tail_pos[b]   = (tail_pos[b] + 1) % QUEUE_DEPTH;
            fill_level[b] = fill_level[b] + 1;
         end
      end else begin
         if (fill_level[b] == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.message     = box_words[b][head_pos[b]];
            head_pos[b]   = (head_pos[b] + 1) % QUEUE_DEPTH;
            fill_level[b] = fill_level[b] - 1;
         end
      end
      return r;
   endfunction

   // one line per mismatch
   task automatic report_mismatch(input string what, input logic [MSG_W-1:0] want,
                                  input logic [MSG_W-1:0] got);
      $display("mailbox mismatch (%s): expected %h got %h", what, want, got);
      mismatches++;
   endtask

   // compare results first, then record the item taken at this edge
   always @(posedge clock) begin : watch
      mail_result_type want;
      if (reset) begin
         for (int b = 0; b < MAILBOX_COUNT; b++) begin
            head_pos[b]   = 0;
            tail_pos[b]   = 0;
            fill_level[b] = 0;
         end
         awaited_results.delete();
         results_seen <= 0;
      end else begin
         if (rsp_valid) begin
            results_seen <= results_seen + 1;
            if (awaited_results.size() == 0) begin
               report_mismatch("result with none awaited", '0, rsp_received_message);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", MSG_W'(want.status), MSG_W'(rsp_status));
               if (rsp_received_message !== want.message)
                  report_mismatch("received message", want.message, rsp_received_message);
            end
         end
         if (start && !busy)
            awaited_results.push_back(predict_mailbox_item(req_mode, req_mailbox,
                                                           req_message));
         if (drain_check) begin
            while (awaited_results.size() != 0) begin
               want = awaited_results.pop_front();
               report_mismatch("result never arrived", want.message, '0);
            end
         end
      end
   end

endmodule

// File: bench/per_process_message_mailbox_test.sv
// ----------------------------------------------------------------------------
// per_process_message_mailbox_test
// stimulus and verdict for the per-process message mailbox
// ----------------------------------------------------------------------------
// Drives send and receive items: a directed opening (extreme fields, empty
// and full mailboxes, pointer wrap) and then three random phases that push a
// few mailboxes between empty and full, with the sender idling at 8 percent,
// then 60 percent, then not at all. A checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module per_process_message_mailbox_test;
   import ppmm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic [MODE_W-1:0]   req_mode    = MODE_SEND;
   logic [BOX_IN_W-1:0] req_mailbox = '0;
   logic [MSG_W-1:0]    req_message = '0;
   logic                drain_check = 1'b0;
   logic                busy;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [MSG_W-1:0]    rsp_received_message;

   int items_sent    = 0;
   int results_seen;
   int fail_count;
   int cycle_count   = 0;
   int send_idle_pct = 0;

   always #10 clock = ~clock;

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("per_process_message_mailbox test failed");
         $finish;
      end
   end

   per_process_message_mailbox DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_mode             (req_mode),
      .req_mailbox          (req_mailbox),
      .req_message          (req_message),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_received_message (rsp_received_message)
   );

   mailbox_checker result_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_mode             (req_mode),
      .req_mailbox          (req_mailbox),
      .req_message          (req_message),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_received_message (rsp_received_message),
      .drain_check          (drain_check),
      .results_seen         (results_seen),
      .fail_count           (fail_count)
   );

   // present one item, idling cycle by cycle first, and wait until taken
   task automatic issue_item(input logic [MODE_W-1:0] mode,
                             input logic [BOX_IN_W-1:0] box,
                             input logic [MSG_W-1:0] msg);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_mode    <= mode;
      req_mailbox <= box;
      req_message <= msg;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // stop sending until every item has had its result
   task automatic wait_for_results;
      start <= 1'b0;
      @(posedge clock);
      while (results_seen != items_sent) @(posedge clock);
   endtask

   // random traffic on a couple of favoured mailboxes, tide of sends and receives
   task automatic random_burst(input int count);
      logic [BOX_IN_W-1:0] focus [2];
      logic [MODE_W-1:0]   mode;
      logic [BOX_IN_W-1:0] box;
      logic [MSG_W-1:0]    msg;
      int                  recv_pct;
      recv_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 120 == 0) begin
            focus[0] = BOX_IN_W'($urandom_range(63));
            focus[1] = BOX_IN_W'($urandom_range(63));
         end
         if (i % 60 == 0)
            case ($urandom_range(2))
               0:       recv_pct = 15;
               1:       recv_pct = 50;
               default: recv_pct = 85;
            endcase
         mode = ($urandom_range(99) < recv_pct) ? MODE_RECV : MODE_SEND;
         box  = ($urandom_range(9) == 0) ? BOX_IN_W'($urandom_range(63))
                                         : focus[1'($urandom_range(1))];
         case ($urandom_range(9))
            0:       msg = '0;
            1:       msg = '1;
            default: msg = {$urandom, $urandom};
         endcase
         issue_item(mode, box, msg);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // receive from an empty mailbox
      issue_item(MODE_RECV, 6'd0, '1);
      // extreme mailboxes and messages
      issue_item(MODE_SEND, 6'd0, '1);
      issue_item(MODE_SEND, 6'd63, '0);
      issue_item(MODE_RECV, 6'd63, '1);
      issue_item(MODE_RECV, 6'd0, '0);
      // fill one mailbox, then a send to the full mailbox
      for (int k = 0; k < 16; k++)
         issue_item(MODE_SEND, 6'd5, {$urandom, $urandom});
      issue_item(MODE_SEND, 6'd5, '1);
      // free a slot and refill it, so the write position wraps
      issue_item(MODE_RECV, 6'd5, '0);
      issue_item(MODE_SEND, 6'd5, {$urandom, $urandom});
      issue_item(MODE_SEND, 6'd5, {$urandom, $urandom});

      // sender idles now and then
      send_idle_pct = 8;
      random_burst(300);
      wait_for_results();

      // sender idles often
      send_idle_pct = 60;
      random_burst(300);

      // back to back
      send_idle_pct = 0;
      random_burst(300);

      wait_for_results();
      repeat (8) @(posedge clock);
      drain_check <= 1'b1;
      @(posedge clock);
      drain_check <= 1'b0;
      @(posedge clock);

      if (fail_count == 0)
         $display("per_process_message_mailbox test passed");
      else
         $display("per_process_message_mailbox test failed");
      $finish;
   end

endmodule
